// ===== rtl/core/ssmfw_pkg.sv =====
package ssmfw_pkg;

    // One input beat: sensor kind and signed reading.
    typedef struct packed {
        logic [1:0]         sensor_kind;
        logic signed [15:0] measurement;
    } t_in;

    // One output beat: a bus byte and its strobe framing flags.
    typedef struct packed {
        logic [7:0] bus_byte;
        logic       frame_start;
        logic       frame_end;
        logic       last;
    } t_out;

    // Digit extraction payload. quot is the part still to be split,
    // digits collects the remainders, least significant digit ending at [0].
    typedef struct packed {
        logic [1:0]       kind;
        logic             neg;
        logic [15:0]      quot;
        logic [3:0][3:0]  digits;
    } t_dig;

    // The eight segment codes of the display line, position 0 first.
    typedef struct packed {
        logic [7:0][7:0] seg;
    } t_line;

    localparam logic [7:0]  CMD_AUTO_INC   = 8'h40;
    localparam logic [7:0]  CMD_ADDR_ZERO  = 8'hC0;
    localparam logic [15:0] RECIP_TEN      = 16'hCCCD;
    localparam int          RECIP_SHIFT    = 19;
    localparam int          BYTES_PER_ITEM = 36;

    localparam logic [1:0] KIND_TEMP  = 2'd0;
    localparam logic [1:0] KIND_LIGHT = 2'd1;
    localparam logic [1:0] KIND_DIST  = 2'd2;

    function automatic logic [7:0] digit_seg(input logic [3:0] d);
        logic [7:0] s;
        case (d)
            4'd0:    s = 8'h3f;
            4'd1:    s = 8'h06;
            4'd2:    s = 8'h5b;
            4'd3:    s = 8'h4f;
            4'd4:    s = 8'h66;
            4'd5:    s = 8'h6d;
            4'd6:    s = 8'h7d;
            4'd7:    s = 8'h07;
            4'd8:    s = 8'h7f;
            4'd9:    s = 8'h6f;
            default: s = 8'h00;
        endcase
        return s;
    endfunction

    // Segment code of label character pos for a sensor kind.
    function automatic logic [7:0] label_seg(input logic [1:0] kind, input logic [1:0] pos);
        logic [7:0] s;
        s = 8'h00;
        unique case (kind)
            KIND_TEMP: begin
                case (pos)
                    2'd0:    s = 8'h78;
                    2'd1:    s = 8'h79;
                    2'd2:    s = 8'h15;
                    default: s = 8'h73;
                endcase
            end
            KIND_LIGHT: begin
                case (pos)
                    2'd0:    s = 8'h38;
                    2'd1:    s = 8'h30;
                    default: s = 8'h00;
                endcase
            end
            KIND_DIST: begin
                case (pos)
                    2'd0:    s = 8'h5e;
                    2'd1:    s = 8'h30;
                    2'd2:    s = 8'h6d;
                    default: s = 8'h78;
                endcase
            end
            default: s = 8'h00;
        endcase
        return s;
    endfunction

    function automatic logic [7:0] unit_seg(input logic [1:0] kind);
        logic [7:0] s;
        unique case (kind)
            KIND_TEMP:  s = 8'he3;
            KIND_LIGHT: s = 8'h73;
            KIND_DIST:  s = 8'h39;
            default:    s = 8'h00;
        endcase
        return s;
    endfunction

endpackage

// ===== rtl/core/seven_segment_measurement_frame_writer.sv =====
// Channel  Direction  Payload   Handshake
// in       input      t_in      i_in_valid / o_in_ready
// out      output     t_out     o_out_valid / i_out_ready
//
// Each input beat yields 36 output beats, one per cycle while the sink is
// ready; the byte serializer bounds the rate and loads the next line as it
// sends the last byte. The first byte follows the registered input stage,
// the divide stages, the line composer and the serializer load.
// Reset is synchronous and active low; it clears all valid bits and the
// serializer counter. A stall holds every stage whose successor is full.
module seven_segment_measurement_frame_writer (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  ssmfw_pkg::t_in  i_in_item,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output ssmfw_pkg::t_out o_out_beat
);
    import ssmfw_pkg::*;

    localparam int NUM_DIV = 4;

    // Input stage: take the magnitude of the reading. The most negative
    // reading wraps to 0x8000, which is the correct unsigned magnitude.
    logic r_s0_valid;
    t_dig r_s0;
    t_dig n_s0;
    logic s0_ready;

    always_comb begin
        n_s0.kind   = i_in_item.sensor_kind;
        n_s0.neg    = i_in_item.measurement[15];
        n_s0.quot   = i_in_item.measurement[15] ? (16'd0 - i_in_item.measurement)
                                                : i_in_item.measurement;
        n_s0.digits = '0;
    end

    assign o_in_ready = !r_s0_valid || s0_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_s0_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready) begin
            r_s0 <= n_s0;
        end
    end

    // Four divide-by-ten stages peel off the four low digits; what remains
    // in the quotient is the fifth digit.
    logic [NUM_DIV:0] div_valid;
    logic [NUM_DIV:0] div_ready;
    t_dig             div_data [NUM_DIV+1];

    assign div_valid[0] = r_s0_valid;
    assign div_data[0]  = r_s0;
    assign s0_ready     = div_ready[0];

    for (genvar g = 0; g < NUM_DIV; g++) begin : g_div
        ssmfw_div10 u_div (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (div_valid[g]),
            .o_ready (div_ready[g]),
            .i_data  (div_data[g]),
            .o_valid (div_valid[g+1]),
            .i_ready (div_ready[g+1]),
            .o_data  (div_data[g+1])
        );
    end

    // Line composition: label, right-aligned number and unit as segment codes.
    logic  line_valid;
    logic  line_ready;
    t_line line_data;

    ssmfw_compose u_compose (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (div_valid[NUM_DIV]),
        .o_ready (div_ready[NUM_DIV]),
        .i_data  (div_data[NUM_DIV]),
        .o_valid (line_valid),
        .i_ready (line_ready),
        .o_data  (line_data)
    );

    // The serializer walks the four strobe frames one beat per cycle while the sink is ready.
    logic [5:0] ser_count;

    ssmfw_serializer u_ser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (line_valid),
        .o_ready (line_ready),
        .i_data  (line_data),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_data  (o_out_beat),
        .o_count (ser_count)
    );

    // The byte counter never runs past the final byte of a frame set.
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (ser_count <= 6'(BYTES_PER_ITEM - 1)))
        else $error("serializer count out of range");

    // The final byte always closes a strobe frame.
    a_last_ends_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_beat.last) |-> o_out_beat.frame_end)
        else $error("last byte without frame end");

    // A frame only ever opens on a command byte.
    a_start_is_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_beat.frame_start) |->
            (o_out_beat.bus_byte == CMD_AUTO_INC || o_out_beat.bus_byte == CMD_ADDR_ZERO))
        else $error("frame start on a data byte");

    // Once a byte other than the last is taken, the next one follows at once.
    a_no_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_ready && !o_out_beat.last) |=> o_out_valid)
        else $error("gap inside a frame set");

endmodule

// ===== rtl/core/ssmfw_div10.sv =====
module ssmfw_div10 (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  ssmfw_pkg::t_dig i_data,
    output logic           o_valid,
    input  logic           i_ready,
    output ssmfw_pkg::t_dig o_data
);
    import ssmfw_pkg::*;

    logic        r_valid;
    t_dig        r_data;
    t_dig        n_data;
    logic [31:0] prod;
    logic [15:0] q;
    logic [15:0] rem;

    // Divide by ten through the reciprocal, exact for any 16-bit value.
    always_comb begin
        prod = i_data.quot * RECIP_TEN;
        q    = 16'(prod[31:RECIP_SHIFT]);
        rem  = i_data.quot - ((q << 3) + (q << 1));
        n_data        = i_data;
        n_data.quot   = q;
        n_data.digits = {rem[3:0], i_data.digits[3:1]};
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

// ===== rtl/core/ssmfw_compose.sv =====
module ssmfw_compose (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  ssmfw_pkg::t_dig  i_data,
    output logic            o_valid,
    input  logic            i_ready,
    output ssmfw_pkg::t_line o_data
);
    import ssmfw_pkg::*;

    logic            r_valid;
    t_line           r_data;
    t_line           n_data;
    logic [4:0][3:0] d;
    logic [2:0]      nd;
    logic [2:0]      numlen;
    logic [2:0]      w;

    always_comb begin
        logic [2:0] jj;
        logic [2:0] k;
        d = {i_data.quot[3:0], i_data.digits};
        if (d[4] != 4'd0) begin
            nd = 3'd5;
        end else if (d[3] != 4'd0) begin
            nd = 3'd4;
        end else if (d[2] != 4'd0) begin
            nd = 3'd3;
        end else if (d[1] != 4'd0) begin
            nd = 3'd2;
        end else begin
            nd = 3'd1;
        end
        numlen = nd + {2'b00, i_data.neg};
        w      = (numlen < 3'd3) ? 3'd3 : numlen;
        for (int p = 0; p < 4; p++) begin
            n_data.seg[p] = label_seg(i_data.kind, 2'(p));
        end
        // The number field is w wide and right-aligned; the minus sign and
        // padding are blank, so only digits and the unit light segments.
        for (int j = 0; j < 4; j++) begin
            jj = 3'(j);
            k  = w - 3'd1 - jj;
            if (jj == w) begin
                n_data.seg[4 + j] = unit_seg(i_data.kind);
            end else if (k < nd) begin
                n_data.seg[4 + j] = digit_seg(d[k]);
            end else begin
                n_data.seg[4 + j] = 8'h00;
            end
        end
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

// ===== rtl/core/ssmfw_serializer.sv =====
module ssmfw_serializer (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  ssmfw_pkg::t_line  i_data,
    output logic             o_valid,
    input  logic             i_ready,
    output ssmfw_pkg::t_out   o_data,
    output logic [5:0]       o_count
);
    import ssmfw_pkg::*;

    localparam logic [5:0] IDX_CMD1   = 6'd0;
    localparam logic [5:0] IDX_ADDR1  = 6'd1;
    localparam logic [5:0] IDX_CLR_HI = 6'd17;
    localparam logic [5:0] IDX_CMD2   = 6'd18;
    localparam logic [5:0] IDX_ADDR2  = 6'd19;
    localparam logic [5:0] IDX_SEG0   = 6'd20;
    localparam logic [5:0] IDX_LAST   = 6'(BYTES_PER_ITEM - 1);

    logic       r_busy;
    logic [5:0] r_cnt;
    t_line      r_line;
    logic       done;
    logic       load;
    logic [5:0] p;

    assign done    = r_busy && i_ready && (r_cnt == IDX_LAST);
    assign o_ready = !r_busy || done;
    assign load    = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (load) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (done) begin
            r_busy <= 1'b0;
        end else if (r_busy && i_ready) begin
            r_cnt <= r_cnt + 6'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_line <= i_data;
        end
    end

    always_comb begin
        p      = r_cnt - IDX_SEG0;
        o_data = '0;
        o_data.last      = (r_cnt == IDX_LAST);
        o_data.frame_end = (r_cnt == IDX_CMD1) || (r_cnt == IDX_CLR_HI)
                           || (r_cnt == IDX_CMD2) || (r_cnt == IDX_LAST);
        if (r_cnt == IDX_CMD1 || r_cnt == IDX_CMD2) begin
            o_data.bus_byte    = CMD_AUTO_INC;
            o_data.frame_start = 1'b1;
        end else if (r_cnt == IDX_ADDR1 || r_cnt == IDX_ADDR2) begin
            o_data.bus_byte    = CMD_ADDR_ZERO;
            o_data.frame_start = 1'b1;
        end else if (r_cnt >= IDX_SEG0 && !p[0]) begin
            o_data.bus_byte = r_line.seg[p[3:1]];
        end else begin
            o_data.bus_byte = 8'h00;
        end
    end

    assign o_valid = r_busy;
    assign o_count = r_cnt;

endmodule
